>>> sv/hmsd_pkg.sv
// Shared types, constants and helpers of the height map step detector.
// Used by every module of the block; depends on nothing else.
package hmsd_pkg;

	localparam int MAX_ROW_WIDTH = 256;
	localparam int MAX_ROW_TOTAL = 4096;
	localparam int MIN_DIM       = 3;
	localparam int HEIGHT_BITS   = 16;
	localparam int COL_BITS      = $clog2(MAX_ROW_WIDTH);
	localparam int ROW_BITS      = $clog2(MAX_ROW_TOTAL);
	localparam int TOL_BITS      = 16;
	localparam int WIDTH_BITS    = 9;
	localparam int TOTAL_BITS    = 13;
	localparam int CFG_BITS      = 16;
	localparam int CHAIN_LEN     = 3;

	localparam logic [TOL_BITS-1:0]   TOL_RESET   = 16'd8;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 9'd161;
	localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 13'd161;

	typedef enum logic [1:0] {
		REG_STEP_TOL  = 2'd0,
		REG_ROW_WIDTH = 2'd1,
		REG_ROW_TOTAL = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		CLASS_UNKNOWN  = 2'd0,
		CLASS_OCCUPIED = 2'd1,
		CLASS_FREE     = 2'd2
	} class_t;

	typedef struct packed {
		logic signed [HEIGHT_BITS-1:0] cell_height;
		logic                          cell_known;
	} cell_t;

	typedef struct packed {
		class_t cell_class;
		logic   frame_last;
	} result_t;

	typedef struct packed {
		logic                          known;
		logic signed [HEIGHT_BITS-1:0] height;
	} sample_t;

	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t bot;
	} column_t;

	typedef struct packed {
		logic emit;
		logic cls_en;
		logic last;
	} ctrl_t;

	// A neighbor is steep when its height differs from the center by at least
	// the tolerance. An unknown neighbor counts as equal to the center.
	function automatic logic hmsd_steep(logic signed [HEIGHT_BITS-1:0] centre,
			sample_t nb, logic [TOL_BITS-1:0] tol);
		logic signed [HEIGHT_BITS:0] diff;
		logic        [HEIGHT_BITS:0] mag;
		diff = nb.known ? ({nb.height[HEIGHT_BITS-1], nb.height}
			- {centre[HEIGHT_BITS-1], centre}) : '0;
		mag = diff[HEIGHT_BITS] ? (HEIGHT_BITS+1)'(1) + ~diff : diff;
		return mag >= {1'b0, tol};
	endfunction

endpackage

>>> sv/hmsd_line_buffer.sv
// Two line stores holding the previous and the older row of samples.
// Registered read at one column, write of the column read one step before.
// Depends on hmsd_pkg.
module hmsd_line_buffer import hmsd_pkg::*; (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [COL_BITS-1:0] rd_addr,
	input  logic                wr_en,
	input  logic [COL_BITS-1:0] wr_addr,
	input  sample_t             wr_sample,
	output sample_t             prev_rd,
	output sample_t             older_rd
);

	sample_t prev_mem  [MAX_ROW_WIDTH];
	sample_t older_mem [MAX_ROW_WIDTH];
	sample_t prev_rd_q;
	sample_t older_rd_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			prev_rd_q  <= prev_mem[rd_addr];
			older_rd_q <= older_mem[rd_addr];
		end
		if (wr_en) begin
			prev_mem[wr_addr]  <= wr_sample;
			older_mem[wr_addr] <= prev_rd_q;
		end
	end

	assign prev_rd  = prev_rd_q;
	assign older_rd = older_rd_q;

endmodule

>>> sv/hmsd_column_cell.sv
// One column of the three-column neighborhood window.
// Takes a column from its neighbor on each shift and hands its own on.
// Depends on hmsd_pkg.
module hmsd_column_cell import hmsd_pkg::*; (
	input  logic    clk,
	input  logic    shift,
	input  column_t col_in,
	output column_t col_out
);

	column_t col_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

>>> sv/height_map_step_detector.sv
// Top level of the height map step detector.
// Depends on hmsd_pkg, hmsd_line_buffer and hmsd_column_cell.
//
// Height map cells enter in raster order on the cell channel, one transaction
// per cell, and class results leave on the result channel. Both channels use
// valid and stall; a transaction completes on a rising edge with valid high
// and stall low. Each cell is classified as unknown, occupied or free from
// its four neighbors, so the result for a cell leaves after the input that
// follows it by row_width + 1 cells, through s1, s2 and the result register.
// One cell is taken per clock cycle while the result side keeps up; the
// limit is the single read and write port of each line store.
// The last row_width + 1 results of a frame leave during the first inputs
// of the next frame; frame_last marks the final one.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so while the block is idle, which the block
// does not enforce. Reset restores the register defaults, clears the row
// and column counters and empties the pipeline; the line stores are not
// cleared. A stall on the result channel holds the result register, and
// once the pipeline behind it is full, stall is raised on the cell channel.
module height_map_step_detector import hmsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cell_valid,
	output logic                cell_stall,
	input  cell_t               map_cell,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	logic [TOL_BITS-1:0]   tol_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [WIDTH_BITS-1:0] w_eff;
	logic [TOTAL_BITS-1:0] h_eff;

	logic [COL_BITS-1:0]   col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic                  tail_q;

	logic                  wrap_pre;
	logic [TOTAL_BITS-1:0] row_try;
	logic [COL_BITS-1:0]   c_cur;
	logic [ROW_BITS-1:0]   r_cur;
	logic [WIDTH_BITS-1:0] col_inc;
	logic [TOTAL_BITS-1:0] row_inc;
	logic                  end_row;
	logic                  end_frame;
	ctrl_t                 ctrl_in;

	logic                  accept;
	logic                  adv1;
	logic                  adv2;

	logic                  valid_s1;
	ctrl_t                 ctrl_s1;
	logic [COL_BITS-1:0]   addr_s1;
	sample_t               cur_s1;
	logic                  valid_s2;
	ctrl_t                 ctrl_s2;

	sample_t               prev_rd;
	sample_t               older_rd;
	column_t               chain_in  [CHAIN_LEN];
	column_t               chain_out [CHAIN_LEN];

	sample_t               centre;
	class_t                cls;
	result_t               result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			width_q <= WIDTH_RESET;
			total_q <= TOTAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_TOL:  tol_q   <= cfg_data[TOL_BITS-1:0];
				REG_ROW_WIDTH: width_q <= cfg_data[WIDTH_BITS-1:0];
				REG_ROW_TOTAL: total_q <= cfg_data[TOTAL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_BITS'(MIN_DIM)) begin
			w_eff = WIDTH_BITS'(MIN_DIM);
		end else if (width_q > WIDTH_BITS'(MAX_ROW_WIDTH)) begin
			w_eff = WIDTH_BITS'(MAX_ROW_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (total_q < TOTAL_BITS'(MIN_DIM)) begin
			h_eff = TOTAL_BITS'(MIN_DIM);
		end else if (total_q > TOTAL_BITS'(MAX_ROW_TOTAL)) begin
			h_eff = TOTAL_BITS'(MAX_ROW_TOTAL);
		end else begin
			h_eff = total_q;
		end
	end

	always_comb begin
		wrap_pre  = {1'b0, col_q} >= w_eff;
		c_cur     = wrap_pre ? '0 : col_q;
		row_try   = {1'b0, row_q} + (wrap_pre ? TOTAL_BITS'(1) : '0);
		r_cur     = (row_try >= h_eff) ? '0 : row_try[ROW_BITS-1:0];
		col_inc   = {1'b0, c_cur} + WIDTH_BITS'(1);
		row_inc   = {1'b0, r_cur} + TOTAL_BITS'(1);
		end_row   = col_inc >= w_eff;
		end_frame = end_row && (row_inc >= h_eff);
		ctrl_in.emit   = (r_cur >= ROW_BITS'(2)) || (r_cur != '0 && c_cur != '0) || tail_q;
		ctrl_in.cls_en = (r_cur >= ROW_BITS'(2)) && (c_cur >= COL_BITS'(2));
		ctrl_in.last   = tail_q && (r_cur == ROW_BITS'(1)) && (c_cur == '0);
	end

	assign adv2       = valid_s2 && (!ctrl_s2.emit || !result_valid || !result_stall);
	assign adv1       = valid_s1 && (!valid_s2 || adv2);
	assign cell_stall = valid_s1 && !adv1;
	assign accept     = cell_valid && !cell_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			tail_q <= 1'b0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_inc[ROW_BITS-1:0];
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
				row_q <= r_cur;
			end
			if (end_frame) begin
				tail_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2 && ctrl_s2.emit) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1       <= ctrl_in;
			addr_s1       <= c_cur;
			cur_s1.known  <= map_cell.cell_known;
			cur_s1.height <= map_cell.cell_height;
		end
		if (adv1) begin
			ctrl_s2 <= ctrl_s1;
		end
		if (adv2 && ctrl_s2.emit) begin
			result_q.cell_class <= cls;
			result_q.frame_last <= ctrl_s2.last;
		end
	end

	hmsd_line_buffer u_line_buffer (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (c_cur),
		.wr_en     (adv1),
		.wr_addr   (addr_s1),
		.wr_sample (cur_s1),
		.prev_rd   (prev_rd),
		.older_rd  (older_rd)
	);

	assign chain_in[0].top = older_rd;
	assign chain_in[0].mid = prev_rd;
	assign chain_in[0].bot = cur_s1;

	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign chain_in[i] = chain_out[i-1];
		end
		hmsd_column_cell u_cell (
			.clk     (clk),
			.shift   (adv1),
			.col_in  (chain_in[i]),
			.col_out (chain_out[i])
		);
	end

	// The newest column sits in the first cell, the center column in the
	// second and the oldest column in the third.
	always_comb begin
		centre = chain_out[1].mid;
		if (!ctrl_s2.cls_en || !centre.known) begin
			cls = CLASS_UNKNOWN;
		end else if (hmsd_steep(centre.height, chain_out[1].top, tol_q)
				|| hmsd_steep(centre.height, chain_out[2].mid, tol_q)
				|| hmsd_steep(centre.height, chain_out[1].bot, tol_q)
				|| hmsd_steep(centre.height, chain_out[0].mid, tol_q)) begin
			cls = CLASS_OCCUPIED;
		end else begin
			cls = CLASS_FREE;
		end
	end

	assign result = result_q;

endmodule
